FILE: src/cqsr_pkg.sv
package cqsr_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int WORD_W             = 32;
  localparam int REQ_TYPE_W         = 2;
  localparam int OUT_CNT_W          = 5;
  localparam int Q_DEPTH            = 2;
  localparam int Q_PTR_W            = 1;
  localparam int Q_FILL_W           = $clog2(Q_DEPTH + 1);

  typedef enum logic [REQ_TYPE_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP,
    BK_SRCH,
    BK_REV_A,
    BK_REV_B
  } back_state_t;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     found;
    logic [OUT_CNT_W-1:0]     position;
    logic [OUT_CNT_W-1:0]     occupancy;
    status_t                  status;
  } rsp_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  function automatic op_t decode_op(input logic [REQ_TYPE_W-1:0] code);
    return op_t'(code);
  endfunction

endpackage

FILE: src/cqsr_stream_if.sv
interface cqsr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/cqsr_ram.sv
module cqsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: src/cqsr_front.sv
module cqsr_front import cqsr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cqsr_stream_if.sink   req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cmd_t          cmd
);

  logic fr_valid;
  cmd_t fr_cmd;

  assign req.ready = !fr_valid || cmd_ready;
  assign cmd_valid = fr_valid;
  assign cmd       = fr_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (req.ready) begin
      fr_valid <= req.valid;
      if (req.valid) begin
        fr_cmd.op    <= decode_op(req.data.req_type);
        fr_cmd.value <= req.data.value;
      end
    end
  end

endmodule

FILE: src/cqsr_queue.sv
module cqsr_queue import cqsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_FILL_W-1:0] fill;
  logic                do_wr;
  logic                do_rd;

  assign in_ready  = fill != Q_FILL_W'(Q_DEPTH);
  assign out_valid = fill != '0;
  assign out_cmd   = entries[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        entries[wr_ptr] <= in_cmd;
        wr_ptr          <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + Q_FILL_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - Q_FILL_W'(1);
      end
    end
  end

endmodule

FILE: src/cqsr_back.sv
module cqsr_back import cqsr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  cqsr_stream_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [WORD_W-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] ext;
    ext = 64'($signed(w));
    return ext[WORD_W-1:0];
  endfunction

  back_state_t           state;
  back_state_t           state_next;
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] key;
  logic [CW-1:0]         cmp_idx;
  logic [AW-1:0]         rd_slot;
  logic [AW-1:0]         lo_slot;
  logic [AW-1:0]         hi_slot;
  logic [CW-1:0]         pairs;
  logic [DATA_WIDTH-1:0] tmp;
  logic                  out_valid;
  rsp_t                  out_data;

  logic                  out_free;
  logic                  take;
  logic                  is_full;
  logic                  hit;
  logic                  last_cmp;
  logic                  load_res;
  rsp_t                  res_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;

  cqsr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign cmd_ready = (state == BK_IDLE) && out_free;
  assign take      = cmd_ready && cmd_valid;
  assign is_full   = count == CW'(DEPTH);
  assign hit       = rdata_a == key;
  assign last_cmp  = (cmp_idx + CW'(1)) == count;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_POP:     if (count != '0) state_next = BK_POP;
            OP_SEARCH:  if (count != '0) state_next = BK_SRCH;
            OP_REVERSE: if (count > CW'(1)) state_next = BK_REV_A;
            default:    state_next = BK_IDLE;
          endcase
        end
      end
      BK_POP:   state_next = BK_IDLE;
      BK_SRCH:  if (hit || last_cmp) state_next = BK_IDLE;
      BK_REV_A: state_next = BK_REV_B;
      BK_REV_B: state_next = (pairs == CW'(1)) ? BK_IDLE : BK_REV_A;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr_a  = '0;
    raddr_b  = '0;
    load_res = 1'b0;
    res_next = '{popped_value: '0, found: 1'b0, position: '0,
                 occupancy: OUT_CNT_W'(count), status: ST_DONE};
    case (state)
      BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_PUSH: begin
              load_res = 1'b1;
              if (is_full) begin
                res_next.status = ST_FULL;
              end else begin
                we                 = 1'b1;
                waddr              = slot_add(head, count);
                wdata              = to_word(cmd.value);
                res_next.occupancy = OUT_CNT_W'(count + CW'(1));
              end
            end
            OP_POP: begin
              raddr_a = head;
              if (count == '0) begin
                load_res        = 1'b1;
                res_next.status = ST_EMPTY;
              end
            end
            OP_SEARCH: begin
              raddr_a = head;
              if (count == '0) load_res = 1'b1;
            end
            default: begin
              raddr_a = head;
              raddr_b = slot_add(head, count - CW'(1));
              if (count < CW'(2)) load_res = 1'b1;
            end
          endcase
        end
      end
      BK_POP: begin
        load_res              = 1'b1;
        res_next.popped_value = from_word(rdata_a);
        res_next.occupancy    = OUT_CNT_W'(count - CW'(1));
      end
      BK_SRCH: begin
        raddr_a = slot_add(rd_slot, CW'(1));
        if (hit) begin
          load_res          = 1'b1;
          res_next.found    = 1'b1;
          res_next.position = OUT_CNT_W'(cmp_idx + CW'(1));
        end else if (last_cmp) begin
          load_res = 1'b1;
        end
      end
      BK_REV_A: begin
        we    = 1'b1;
        waddr = lo_slot;
        wdata = rdata_b;
      end
      BK_REV_B: begin
        we      = 1'b1;
        waddr   = hi_slot;
        wdata   = tmp;
        raddr_a = slot_add(lo_slot, CW'(1));
        raddr_b = slot_dec(hi_slot);
        if (pairs == CW'(1)) load_res = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        out_valid <= 1'b1;
        out_data  <= res_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_IDLE: begin
          if (take) begin
            key     <= to_word(cmd.value);
            cmp_idx <= '0;
            rd_slot <= head;
            lo_slot <= head;
            hi_slot <= slot_add(head, count - CW'(1));
            pairs   <= count >> 1;
            if (cmd.op == OP_PUSH && !is_full) begin
              count <= count + CW'(1);
            end
          end
        end
        BK_POP: begin
          head  <= slot_add(head, CW'(1));
          count <= count - CW'(1);
        end
        BK_SRCH: begin
          cmp_idx <= cmp_idx + CW'(1);
          rd_slot <= slot_add(rd_slot, CW'(1));
        end
        BK_REV_A: begin
          tmp <= rdata_a;
        end
        BK_REV_B: begin
          pairs   <= pairs - CW'(1);
          lo_slot <= slot_add(lo_slot, CW'(1));
          hi_slot <= slot_dec(hi_slot);
        end
        default: begin
          tmp <= tmp;
        end
      endcase
    end
  end

endmodule

FILE: src/circular_queue_search_reverse.sv
// Channel  Role    Handshake      Payload
// req      sink    valid, ready   req_type, value
// rsp      source  valid, ready   popped_value, found, position, occupancy, status
//
// Each request passes a front register and a two-entry queue before the back engine.
// In the back engine a push writes the ring RAM directly and a pop reads the head slot, then
// returns it; a search reads one entry per cycle from the head until a hit or the last entry;
// a reverse swaps floor(count / 2) end pairs, each through BK_REV_A and BK_REV_B.
// Reset is synchronous and empties the queue; the ring RAM needs no clearing.
// The engine takes the next request only when it is idle and its result register is empty or being read.
module circular_queue_search_reverse import cqsr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  cqsr_stream_if.sink   req,
  cqsr_stream_if.source rsp
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  cqsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  cqsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_cmd    (fr_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  cqsr_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp       (rsp)
  );

endmodule
